### hw/rtl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants for the stack bytecode executor.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

  localparam int STACK_DEPTH_DEF  = 1024;
  localparam int GLOBAL_COUNT_DEF = 256;
  localparam int PC_WIDTH_DEF     = 16;

  localparam int WORD_W   = 32;
  localparam int OP_W     = 8;
  localparam int CLEN_W   = 16;
  localparam int STATUS_W = 3;
  localparam int NPC_W    = 16;
  localparam int DEPTH_W  = 11;
  localparam int NEXT_W   = 33;  // unwrapped next address, covers any jump target
  localparam logic [CLEN_W-1:0] CLEN_RESET = 16'hFFFF;
  localparam int LONG_LEN = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 8'd0,
    OP_SWAP   = 8'd1,
    OP_DROP   = 8'd2,
    OP_OVER   = 8'd3,
    OP_ADD    = 8'd4,
    OP_SUB    = 8'd5,
    OP_MUL    = 8'd6,
    OP_DIV    = 8'd7,
    OP_DUP    = 8'd8,
    OP_INC    = 8'd9,
    OP_DEC    = 8'd10,
    OP_GSTORE = 8'd11,
    OP_LOAD   = 8'd12,
    OP_JMP    = 8'd13,
    OP_JZ     = 8'd14,
    OP_HALT   = 8'd15
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    SC_RUN   = 3'd0,
    SC_HALT  = 3'd1,
    SC_OVER  = 3'd2,
    SC_UNDER = 3'd3,
    SC_DIVZ  = 3'd4,
    SC_GLOB  = 3'd5,
    SC_BADOP = 3'd6,
    SC_PCR   = 3'd7
  } stop_code_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic clear_we;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       needs_div;
    logic       div_done;
    logic       out_free;
    stop_code_t stop_code;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/sbe_ram.sv
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sbe_div.sv
// ----------------------------------------------------------------------------
// sbe_div
// Signed 32-bit divide, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [sbe_pkg::WORD_W-1:0] dividend,
  input  wire logic [sbe_pkg::WORD_W-1:0] divisor,
  output logic                            done,
  output logic      [sbe_pkg::WORD_W-1:0] quot
);

  localparam int W  = sbe_pkg::WORD_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W:0]    rem;
  logic [W-1:0]  q;
  logic [W-1:0]  bmag;
  logic          neg;
  logic [W:0]    trial;

  assign trial = {rem[W-1:0], q[W-1]};
  assign quot  = neg ? (~q + 1'b1) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
        bmag <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
        neg  <= dividend[W-1] ^ divisor[W-1];
      end else if (busy) begin
        if (trial >= {1'b0, bmag}) begin
          rem <= trial - {1'b0, bmag};
          q   <= {q[W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sbe_datapath.sv
// ----------------------------------------------------------------------------
// sbe_datapath
// Machine state, stack and globals memories, execute logic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_datapath #(
  parameter int STACK_DEPTH  = sbe_pkg::STACK_DEPTH_DEF,
  parameter int GLOBAL_COUNT = sbe_pkg::GLOBAL_COUNT_DEF,
  parameter int PC_WIDTH     = sbe_pkg::PC_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sbe_pkg::ctrl_cmd_t                cmd,
  output sbe_pkg::dp_stat_t                      stat,
  input  wire logic                              cfg_we,
  input  wire logic [sbe_pkg::CLEN_W-1:0]        cfg_wdata,
  input  wire logic [sbe_pkg::OP_W-1:0]          op,
  input  wire logic [sbe_pkg::WORD_W-1:0]        operand,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic        [sbe_pkg::STATUS_W-1:0]    status,
  output logic        [sbe_pkg::NPC_W-1:0]       next_pc,
  output logic signed [sbe_pkg::WORD_W-1:0]      top_value,
  output logic        [sbe_pkg::DEPTH_W-1:0]     depth
);

  localparam int W    = sbe_pkg::WORD_W;
  localparam int NW   = sbe_pkg::NEXT_W;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int GA_W = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;

  // architectural state
  logic [sbe_pkg::CLEN_W-1:0] code_length;
  logic [PC_WIDTH-1:0]        pc;
  logic [SP_W-1:0]            sp;
  logic [W-1:0]               tos;      // top entry lives here, not in the RAM
  sbe_pkg::stop_code_t        stop;
  logic [sbe_pkg::OP_W-1:0]   op_q;
  logic [W-1:0]               opd_q;
  logic [GA_W-1:0]            clr_addr;

  // next values
  logic [PC_WIDTH-1:0]        pc_next;
  logic [SP_W-1:0]            sp_next;
  logic [W-1:0]               tos_next;
  sbe_pkg::stop_code_t        stop_next;
  sbe_pkg::stop_code_t        code;
  logic [NW-1:0]              nxt;

  logic [W-1:0]  sec;        // entry below top (registered RAM read)
  logic [W-1:0]  gval;
  logic [W-1:0]  quot;
  logic          s_we;
  logic [SA_W-1:0] s_waddr;
  logic          g_we;
  logic [GA_W-1:0] g_waddr;
  logic [W-1:0]  g_wdata;
  logic          sp_empty, sp_lt2, sp_full, glob_bad, long_op;
  logic [SA_W-1:0] sp_m1, sp_m2;
  logic [W-1:0]  mul_res;
  logic          clear_done, needs_div, div_done, out_free;

  assign sp_empty = (sp == '0);
  assign sp_lt2   = (sp < SP_W'(2));
  assign sp_full  = (sp == SP_W'(STACK_DEPTH));
  assign glob_bad = (opd_q >= W'(GLOBAL_COUNT));
  assign sp_m1    = SA_W'(sp - SP_W'(1));
  assign sp_m2    = SA_W'(sp - SP_W'(2));
  assign mul_res  = W'(sec * tos);
  assign long_op  = (op_q == sbe_pkg::OP_PUSH) || (op_q == sbe_pkg::OP_GSTORE) ||
                    (op_q == sbe_pkg::OP_LOAD) || (op_q == sbe_pkg::OP_JMP) ||
                    (op_q == sbe_pkg::OP_JZ);

  // stack: read the entry below top at accept time
  sbe_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH), .AW(SA_W)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (tos),
    .re    (cmd.accept),
    .raddr (SA_W'(sp - SP_W'(2))),
    .rdata (sec)
  );

  sbe_ram #(.WIDTH(W), .DEPTH(GLOBAL_COUNT), .AW(GA_W)) u_glob (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (cmd.accept),
    .raddr (operand[GA_W-1:0]),
    .rdata (gval)
  );

  sbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sec),
    .divisor  (tos),
    .done     (div_done),
    .quot     (quot)
  );

  // execute
  always_comb begin
    logic s_wr, g_wr;
    code     = sbe_pkg::SC_RUN;
    sp_next  = sp;
    tos_next = tos;
    s_wr     = 1'b0;
    s_waddr  = sp_m1;
    g_wr     = 1'b0;
    nxt      = NW'({1'b0, pc} + (PC_WIDTH + 1)'(long_op ? sbe_pkg::LONG_LEN : 1));
    case (op_q)
      sbe_pkg::OP_PUSH: begin
        if (sp_full) begin
          code = sbe_pkg::SC_OVER;
        end else begin
          s_wr = !sp_empty; tos_next = opd_q; sp_next = sp + 1'b1;
        end
      end
      sbe_pkg::OP_SWAP: begin
        if (sp_lt2) begin
          code = sbe_pkg::SC_UNDER;
        end else begin
          s_wr = 1'b1; s_waddr = sp_m2; tos_next = sec;
        end
      end
      sbe_pkg::OP_DROP: begin
        if (sp_empty) begin
          code = sbe_pkg::SC_UNDER;
        end else begin
          tos_next = sec; sp_next = sp - 1'b1;
        end
      end
      sbe_pkg::OP_OVER: begin
        if (sp_lt2) begin
          code = sbe_pkg::SC_UNDER;
        end else if (sp_full) begin
          code = sbe_pkg::SC_OVER;
        end else begin
          s_wr = 1'b1; tos_next = sec; sp_next = sp + 1'b1;
        end
      end
      sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV: begin
        if (sp_lt2) begin
          code = sbe_pkg::SC_UNDER;
        end else if (op_q == sbe_pkg::OP_DIV && tos == '0) begin
          code = sbe_pkg::SC_DIVZ;
        end else begin
          sp_next = sp - 1'b1;
          case (op_q)
            sbe_pkg::OP_ADD: tos_next = sec + tos;
            sbe_pkg::OP_SUB: tos_next = sec - tos;
            sbe_pkg::OP_MUL: tos_next = mul_res;
            default:         tos_next = quot;
          endcase
        end
      end
      sbe_pkg::OP_DUP: begin
        if (sp_empty) begin
          code = sbe_pkg::SC_UNDER;
        end else if (sp_full) begin
          code = sbe_pkg::SC_OVER;
        end else begin
          s_wr = 1'b1; sp_next = sp + 1'b1;
        end
      end
      sbe_pkg::OP_INC, sbe_pkg::OP_DEC: begin
        if (sp_empty) begin
          code = sbe_pkg::SC_UNDER;
        end else begin
          tos_next = (op_q == sbe_pkg::OP_INC) ? tos + 1'b1 : tos - 1'b1;
        end
      end
      sbe_pkg::OP_GSTORE: begin
        if (glob_bad) begin
          code = sbe_pkg::SC_GLOB;
        end else if (sp_empty) begin
          code = sbe_pkg::SC_UNDER;
        end else begin
          g_wr = 1'b1; tos_next = sec; sp_next = sp - 1'b1;
        end
      end
      sbe_pkg::OP_LOAD: begin
        if (glob_bad) begin
          code = sbe_pkg::SC_GLOB;
        end else if (sp_full) begin
          code = sbe_pkg::SC_OVER;
        end else begin
          s_wr = !sp_empty; tos_next = gval; sp_next = sp + 1'b1;
        end
      end
      sbe_pkg::OP_JMP: nxt = NW'(opd_q);
      sbe_pkg::OP_JZ: begin
        if (sp_empty) begin
          code = sbe_pkg::SC_UNDER;
        end else begin
          if (tos == '0) begin
            nxt = NW'(opd_q);
          end
          tos_next = sec; sp_next = sp - 1'b1;
        end
      end
      sbe_pkg::OP_HALT: code = sbe_pkg::SC_HALT;
      default:          code = sbe_pkg::SC_BADOP;
    endcase

    if (code != sbe_pkg::SC_RUN) begin
      sp_next = sp; tos_next = tos; s_wr = 1'b0; g_wr = 1'b0;
    end else if (nxt >= NW'(code_length)) begin
      code = sbe_pkg::SC_PCR;
    end
    pc_next   = nxt[PC_WIDTH-1:0];
    stop_next = code;

    // stopped machine or pc already out of range: nothing executes
    if (stop != sbe_pkg::SC_RUN || NW'(pc) >= NW'(code_length)) begin
      pc_next  = pc; sp_next = sp; tos_next = tos; s_wr = 1'b0; g_wr = 1'b0;
      stop_next = (stop != sbe_pkg::SC_RUN) ? stop : sbe_pkg::SC_PCR;
    end

    s_we    = cmd.commit && s_wr;
    g_we    = cmd.clear_we || (cmd.commit && g_wr);
    g_waddr = cmd.clear_we ? clr_addr : opd_q[GA_W-1:0];
    g_wdata = cmd.clear_we ? '0 : tos;
  end

  assign needs_div  = (stop == sbe_pkg::SC_RUN) && (NW'(pc) < NW'(code_length)) &&
                      (op_q == sbe_pkg::OP_DIV) && !sp_lt2 && (tos != '0);
  assign clear_done = (clr_addr == GA_W'(GLOBAL_COUNT - 1));
  assign out_free   = !out_valid || out_ready;
  assign stat       = {clear_done, needs_div, div_done, out_free, stop};

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= sbe_pkg::CLEN_RESET;
      pc          <= '0;
      sp          <= '0;
      stop        <= sbe_pkg::SC_RUN;
      out_valid   <= 1'b0;
      clr_addr    <= '0;
    end else begin
      if (cfg_we) begin
        code_length <= cfg_wdata;
      end
      if (cmd.clear_we) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.commit) begin
        pc        <= pc_next;
        sp        <= sp_next;
        stop      <= stop_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= op;
      opd_q <= operand;
    end
    if (cmd.commit) begin
      tos       <= tos_next;
      status    <= stop_next;
      next_pc   <= sbe_pkg::NPC_W'(pc_next);
      top_value <= (sp_next != '0) ? tos_next : '0;
      depth     <= sbe_pkg::DEPTH_W'(sp_next);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sbe_ctrl.sv
// ----------------------------------------------------------------------------
// sbe_ctrl
// Sequencer: globals clear, accept, execute, divide wait, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sbe_pkg::dp_stat_t  stat,
  output sbe_pkg::ctrl_cmd_t      cmd
);

  sbe_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbe_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      sbe_pkg::S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (stat.clear_done) begin
          state_next = sbe_pkg::S_IDLE;
        end
      end
      sbe_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = sbe_pkg::S_EXEC;
        end
      end
      sbe_pkg::S_EXEC: begin
        if (stat.needs_div) begin
          cmd.div_start = 1'b1;
          state_next    = sbe_pkg::S_DIV;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = sbe_pkg::S_IDLE;
        end
      end
      sbe_pkg::S_DIV: begin
        if (stat.div_done) begin
          state_next = sbe_pkg::S_FIN;
        end
      end
      sbe_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = sbe_pkg::S_IDLE;
        end
      end
      default: state_next = sbe_pkg::S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/stack_bytecode_executor.sv
// Sequence: an instruction word is accepted in IDLE along with its memory reads,
//   then executed and committed in EXEC; a divide runs in DIV on the bit-serial
//   divider and commits in FIN. No new word is taken until the previous commits.
// Reset (rst, synchronous): pc, stack pointer and stop code clear;
//   code_length = 0xFFFF; then a clearing pass zeroes every globals RAM entry,
//   with in_ready low (config writes still taken).
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// 32-bit stack machine executing one decoded instruction word per input.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_bytecode_executor #(
  parameter int STACK_DEPTH  = sbe_pkg::STACK_DEPTH_DEF,
  parameter int GLOBAL_COUNT = sbe_pkg::GLOBAL_COUNT_DEF,
  parameter int PC_WIDTH     = sbe_pkg::PC_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config: code_length
  input  wire logic                              cfg_we,
  input  wire logic        [sbe_pkg::CLEN_W-1:0] cfg_wdata,
  // instruction words
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic        [sbe_pkg::OP_W-1:0]   op,
  input  wire logic        [sbe_pkg::WORD_W-1:0] operand,
  // result words
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic        [sbe_pkg::STATUS_W-1:0]    status,
  output logic        [sbe_pkg::NPC_W-1:0]       next_pc,
  output logic signed [sbe_pkg::WORD_W-1:0]      top_value,
  output logic        [sbe_pkg::DEPTH_W-1:0]     depth
);

  sbe_pkg::ctrl_cmd_t cmd;
  sbe_pkg::dp_stat_t  stat;

  // Controller owns sequencing only; all machine state lives in the datapath.
  sbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The result register decouples the sides: a new word is accepted while
  // the previous result still waits; commit holds until the slot frees.
  sbe_datapath #(
    .STACK_DEPTH  (STACK_DEPTH),
    .GLOBAL_COUNT (GLOBAL_COUNT),
    .PC_WIDTH     (PC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op        (op),
    .operand   (operand),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .next_pc   (next_pc),
    .top_value (top_value),
    .depth     (depth)
  );

  // commit never overwrites an untaken result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result slot busy");

  // reported depth never exceeds the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(depth) <= 32'(STACK_DEPTH)))
    else $error("depth beyond stack size");

  // a stopped machine stays stopped with the same code
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (stat.stop_code != sbe_pkg::SC_RUN) |=> $stable(stat.stop_code))
    else $error("stop code changed after stop");

  // accept only when idle, never together with a commit or a globals clear
  a_accept_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !cmd.commit && !cmd.clear_we)
    else $error("accept overlaps commit or clear");

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stack bytecode executor: directed script, then
// random legal programs over several code lengths, ending in one stop case.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int NSTACK = sbe_pkg::STACK_DEPTH_DEF;
  localparam int NGLOB  = sbe_pkg::GLOBAL_COUNT_DEF;
  localparam int RAND_PER_PHASE = 440;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 60;   // longer than a divide

  typedef struct packed {
    sbe_pkg::stop_code_t status;
    logic [15:0] npc;
    logic [31:0] top;
    logic [10:0] dep;
  } result_t;

  typedef struct packed {
    logic [7:0]  op;
    logic [31:0] opd;
    bit          typed;    // expected result given literally below
    result_t     want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [sbe_pkg::CLEN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [sbe_pkg::OP_W-1:0] op = '0;
  logic [sbe_pkg::WORD_W-1:0] operand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [sbe_pkg::STATUS_W-1:0] status;
  logic [sbe_pkg::NPC_W-1:0] next_pc;
  logic signed [sbe_pkg::WORD_W-1:0] top_value;
  logic [sbe_pkg::DEPTH_W-1:0] depth;

  stack_bytecode_executor u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .operand(operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .next_pc(next_pc), .top_value(top_value), .depth(depth)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow machine state
  logic [15:0] m_clen;
  logic [15:0] m_pc;
  int          m_sp;
  sbe_pkg::stop_code_t m_stop;
  logic [31:0] m_stack [NSTACK];
  logic [31:0] m_glob  [NGLOB];

  result_t pending_q [$];
  int      errors = 0;
  int      cycles = 0;
  int      burst_left = 0;
  bit      rx_choppy = 1'b0;

  function automatic result_t snapshot();
    result_t r;
    r.status = m_stop;
    r.npc    = m_pc;
    r.top    = (m_sp != 0) ? m_stack[m_sp-1] : 32'h0;
    r.dep    = m_sp[10:0];
    return r;
  endfunction

  function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Execute one word on the shadow machine and return what the block reports
  function automatic result_t exec_word(logic [7:0] o, logic [31:0] d);
    sbe_pkg::stop_code_t code;
    logic [32:0] nxt;
    logic [31:0] a, b, t;
    bit long_op;
    code = sbe_pkg::SC_RUN;
    if (m_stop != sbe_pkg::SC_RUN) return snapshot();
    if (m_pc >= m_clen) begin
      m_stop = sbe_pkg::SC_PCR;
      return snapshot();
    end
    long_op = (o == sbe_pkg::OP_PUSH || o == sbe_pkg::OP_GSTORE || o == sbe_pkg::OP_LOAD ||
               o == sbe_pkg::OP_JMP || o == sbe_pkg::OP_JZ);
    nxt = {17'd0, m_pc} + (long_op ? sbe_pkg::LONG_LEN : 1);
    case (o)
      sbe_pkg::OP_PUSH: begin
        if (m_sp >= NSTACK) code = sbe_pkg::SC_OVER;
        else begin m_stack[m_sp] = d; m_sp++; end
      end
      sbe_pkg::OP_SWAP: begin
        if (m_sp < 2) code = sbe_pkg::SC_UNDER;
        else begin
          t = m_stack[m_sp-1];
          m_stack[m_sp-1] = m_stack[m_sp-2];
          m_stack[m_sp-2] = t;
        end
      end
      sbe_pkg::OP_DROP: begin
        if (m_sp == 0) code = sbe_pkg::SC_UNDER;
        else m_sp--;
      end
      sbe_pkg::OP_OVER: begin
        if (m_sp < 2) code = sbe_pkg::SC_UNDER;
        else if (m_sp >= NSTACK) code = sbe_pkg::SC_OVER;
        else begin m_stack[m_sp] = m_stack[m_sp-2]; m_sp++; end
      end
      sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV: begin
        if (m_sp < 2) code = sbe_pkg::SC_UNDER;
        else begin
          a = m_stack[m_sp-2];
          b = m_stack[m_sp-1];
          if (o == sbe_pkg::OP_DIV && b == 0) code = sbe_pkg::SC_DIVZ;
          else begin
            case (o)
              sbe_pkg::OP_ADD: t = a + b;
              sbe_pkg::OP_SUB: t = a - b;
              sbe_pkg::OP_MUL: t = a * b;
              default:         t = quot_trunc(a, b);
            endcase
            m_stack[m_sp-2] = t;
            m_sp--;
          end
        end
      end
      sbe_pkg::OP_DUP: begin
        if (m_sp == 0) code = sbe_pkg::SC_UNDER;
        else if (m_sp >= NSTACK) code = sbe_pkg::SC_OVER;
        else begin m_stack[m_sp] = m_stack[m_sp-1]; m_sp++; end
      end
      sbe_pkg::OP_INC, sbe_pkg::OP_DEC: begin
        if (m_sp == 0) code = sbe_pkg::SC_UNDER;
        else m_stack[m_sp-1] = m_stack[m_sp-1] +
                               ((o == sbe_pkg::OP_INC) ? 32'd1 : 32'hFFFF_FFFF);
      end
      sbe_pkg::OP_GSTORE: begin
        if (d >= NGLOB) code = sbe_pkg::SC_GLOB;
        else if (m_sp == 0) code = sbe_pkg::SC_UNDER;
        else begin m_glob[d] = m_stack[m_sp-1]; m_sp--; end
      end
      sbe_pkg::OP_LOAD: begin
        if (d >= NGLOB) code = sbe_pkg::SC_GLOB;
        else if (m_sp >= NSTACK) code = sbe_pkg::SC_OVER;
        else begin m_stack[m_sp] = m_glob[d]; m_sp++; end
      end
      sbe_pkg::OP_JMP: nxt = {1'b0, d};
      sbe_pkg::OP_JZ: begin
        if (m_sp == 0) code = sbe_pkg::SC_UNDER;
        else begin
          if (m_stack[m_sp-1] == 0) nxt = {1'b0, d};
          m_sp--;
        end
      end
      sbe_pkg::OP_HALT: code = sbe_pkg::SC_HALT;
      default: code = sbe_pkg::SC_BADOP;
    endcase
    if (code == sbe_pkg::SC_RUN && nxt >= {17'd0, m_clen}) code = sbe_pkg::SC_PCR;
    m_pc   = nxt[15:0];
    m_stop = code;
    return snapshot();
  endfunction

  // Sender: bursts of words separated by random gaps
  task automatic send_word(input logic [7:0] o, input logic [31:0] d,
                           input bit typed, input result_t want);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    r = exec_word(o, d);
    pending_q.push_back(typed ? want : r);
    in_valid = 1'b1;
    op       = o;
    operand  = d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_plain(input logic [7:0] o, input logic [31:0] d);
    send_word(o, d, 1'b0, '0);
  endtask

  // Wait until every result is back, then let the block settle
  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_clen(input logic [15:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    m_clen = v;
  endtask

  function automatic logic [31:0] push_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 9);
      2: return -$urandom_range(1, 9);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Pick a random word that keeps the machine running
  task automatic random_legal();
    logic [7:0] o;
    logic [31:0] d;
    bit ok;
    if ({1'b0, m_pc} + sbe_pkg::LONG_LEN >= {1'b0, m_clen}) begin
      send_plain(sbe_pkg::OP_JMP, $urandom_range(0, m_clen - 6));
      return;
    end
    do begin
      o = (m_sp < 3 && $urandom_range(0, 1)) ? sbe_pkg::OP_PUSH : $urandom_range(0, 14);
      case (o)
        sbe_pkg::OP_SWAP, sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL:
          ok = (m_sp >= 2);
        sbe_pkg::OP_OVER: ok = (m_sp >= 2 && m_sp < NSTACK);
        sbe_pkg::OP_DIV:  ok = (m_sp >= 2) && (m_stack[m_sp-1] != 0);
        sbe_pkg::OP_DROP, sbe_pkg::OP_INC, sbe_pkg::OP_DEC, sbe_pkg::OP_GSTORE,
        sbe_pkg::OP_JZ:   ok = (m_sp >= 1);
        sbe_pkg::OP_DUP:  ok = (m_sp >= 1 && m_sp < NSTACK);
        default:          ok = (m_sp < NSTACK);
      endcase
    end while (!ok);
    case (o)
      sbe_pkg::OP_PUSH:                    d = push_value();
      sbe_pkg::OP_GSTORE, sbe_pkg::OP_LOAD: d = $urandom_range(0, NGLOB - 1);
      sbe_pkg::OP_JMP, sbe_pkg::OP_JZ:     d = $urandom_range(0, m_clen - 6);
      default:                             d = $urandom;   // ignored by one-byte ops
    endcase
    send_plain(o, d);
  endtask

  task automatic random_phase(input int n);
    repeat (n) random_legal();
    send_plain(sbe_pkg::OP_JMP, 32'd0);   // park the pc low before any length change
    drain();
  endtask

  // Directed script; literal expectations only where trivially known
  script_row_t script [25];

  initial begin
    script[0]  = '{sbe_pkg::OP_PUSH, 32'h7FFF_FFFF, 1,
                   '{sbe_pkg::SC_RUN, 16'd5, 32'h7FFF_FFFF, 11'd1}};
    script[1]  = '{sbe_pkg::OP_PUSH, 32'h8000_0000, 1,
                   '{sbe_pkg::SC_RUN, 16'd10, 32'h8000_0000, 11'd2}};
    script[2]  = '{sbe_pkg::OP_ADD,  32'hFFFF_FFFF, 1,
                   '{sbe_pkg::SC_RUN, 16'd11, 32'hFFFF_FFFF, 11'd1}};
    script[3]  = '{sbe_pkg::OP_LOAD, 32'd255,       1,
                   '{sbe_pkg::SC_RUN, 16'd16, 32'h0, 11'd2}};
    script[4]  = '{sbe_pkg::OP_DROP, 32'h0, 0, '0};
    script[5]  = '{sbe_pkg::OP_INC,  32'h0, 0, '0};            // wraps to zero
    script[6]  = '{sbe_pkg::OP_DEC,  32'h0, 0, '0};            // wraps back
    script[7]  = '{sbe_pkg::OP_PUSH, 32'h8000_0000, 0, '0};
    script[8]  = '{sbe_pkg::OP_PUSH, 32'hFFFF_FFFF, 0, '0};
    script[9]  = '{sbe_pkg::OP_DIV,  32'h0, 0, '0};            // most negative / -1
    script[10] = '{sbe_pkg::OP_SWAP, 32'h0, 0, '0};
    script[11] = '{sbe_pkg::OP_OVER, 32'h0, 0, '0};
    script[12] = '{sbe_pkg::OP_SUB,  32'h0, 0, '0};
    script[13] = '{sbe_pkg::OP_MUL,  32'h0, 0, '0};
    script[14] = '{sbe_pkg::OP_PUSH, 32'hFFFF_FFF9, 0, '0};
    script[15] = '{sbe_pkg::OP_PUSH, 32'd2, 0, '0};
    script[16] = '{sbe_pkg::OP_DIV,  32'h0, 0, '0};            // truncates toward zero
    script[17] = '{sbe_pkg::OP_DUP,  32'h0, 0, '0};
    script[18] = '{sbe_pkg::OP_GSTORE, 32'd0, 0, '0};
    script[19] = '{sbe_pkg::OP_GSTORE, 32'd255, 0, '0};
    script[20] = '{sbe_pkg::OP_LOAD, 32'd0, 0, '0};
    script[21] = '{sbe_pkg::OP_JZ,   32'd100, 0, '0};          // nonzero, falls through
    script[22] = '{sbe_pkg::OP_PUSH, 32'd0, 0, '0};
    script[23] = '{sbe_pkg::OP_JZ,   32'd200, 0, '0};          // taken
    script[24] = '{sbe_pkg::OP_JMP,  32'd0, 0, '0};
  end

  // Receiver: stretches of full speed and stretches of random stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) rx_choppy = ~rx_choppy;
    out_ready = rx_choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // Result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result word with nothing pending", $realtime);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.status, status);
          errors++;
        end
        if (next_pc !== e.npc) begin
          $display("%0t: next_pc exp %h got %h", $realtime, e.npc, next_pc);
          errors++;
        end
        if (top_value !== e.top) begin
          $display("%0t: top_value exp %h got %h", $realtime, e.top, top_value);
          errors++;
        end
        if (depth !== e.dep) begin
          $display("%0t: depth exp %0d got %0d", $realtime, e.dep, depth);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    m_clen = sbe_pkg::CLEN_RESET;
    m_pc   = '0;
    m_sp   = 0;
    m_stop = sbe_pkg::SC_RUN;
    foreach (m_stack[i]) m_stack[i] = '0;
    foreach (m_glob[i])  m_glob[i]  = '0;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) send_word(script[i].op, script[i].opd, script[i].typed, script[i].want);
    random_phase(RAND_PER_PHASE);

    // Short program space: frequent wrap jumps
    write_clen(16'd300);
    random_phase(RAND_PER_PHASE);

    write_clen(16'd8000);
    random_phase(RAND_PER_PHASE);

    write_clen(16'hFFFF);

    // One way to stop the machine, picked at random
    case ($urandom_range(0, 5))
      0: send_plain(sbe_pkg::OP_HALT, $urandom);
      1: send_plain($urandom_range(16, 255), $urandom);
      2: send_plain(sbe_pkg::OP_LOAD, $urandom_range(NGLOB, 32'hFFFF_FFFF));
      3: begin
        if (m_sp == 0) send_plain(sbe_pkg::OP_PUSH, $urandom);
        send_plain(sbe_pkg::OP_PUSH, 32'd0);
        send_plain(sbe_pkg::OP_DIV, $urandom);
      end
      4: begin
        while (m_sp > 0) send_plain(sbe_pkg::OP_DROP, $urandom);
        send_plain(sbe_pkg::OP_DROP, $urandom);
      end
      default: send_plain(sbe_pkg::OP_JMP,
                          $urandom_range(0, 1) ? 32'h0000_FFFF : ($urandom | 32'h1_0000));
    endcase
    // Stopped: everything after is ignored
    repeat (4) send_plain($urandom_range(0, 255), $urandom);
    drain();

    write_clen(16'd0);
    repeat (3) send_plain($urandom_range(0, 255), $urandom);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
